// ===== hw/rtl/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and the month length lookup for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned COUNT_W = 16;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// year / 100 by reciprocal: (year * 5243) >> 19, exact for year < 16384
	localparam int unsigned        RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_C100  = 13'd5243;
	localparam int unsigned        RECIP_SHIFT = 19;
	localparam int unsigned        QUO_W       = 8;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture a new transaction
		logic quo;      // register year / 100
		logic leap;     // register the leap year flag
		logic step;     // subtract one month length and advance the month
		logic emit;     // copy the date into the result register
	} gdad_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic more;     // day still exceeds the current month length
		logic wrap;     // current month is December
	} gdad_sts_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
	                                               input logic leap);
		logic [DAY_W-1:0] len;
		len = 5'd31;
		unique case (month)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== hw/rtl/gdad_ifs.sv =====
// ----------------------------------------------------------------------------
// gdad_ifs
// Valid/ready channels for the start date request and the end date result.
// ----------------------------------------------------------------------------
interface gdad_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  start_day;
	logic [3:0]  start_month;
	logic [13:0] start_year;
	logic [15:0] add_days;

	modport source (output valid, start_day, start_month, start_year, add_days,
	                input ready);
	modport sink   (input valid, start_day, start_month, start_year, add_days,
	                output ready);
endinterface

interface gdad_rsp_if;
	logic        valid;
	logic        ready;
	logic [4:0]  end_day;
	logic [3:0]  end_month;
	logic [13:0] end_year;

	modport source (output valid, end_day, end_month, end_year, input ready);
	modport sink   (input valid, end_day, end_month, end_year, output ready);
endinterface

// ===== hw/rtl/gdad_dpath.sv =====
// ----------------------------------------------------------------------------
// gdad_dpath
// Day, month and year registers, leap year evaluation, month subtraction and
// the result register.
// ----------------------------------------------------------------------------
module gdad_dpath
	import gdad_pkg::*;
#(
	parameter int unsigned DAY_COUNT_BITS = 16
) (
	input  logic                clk,
	input  gdad_cmd_t           cmd,
	output gdad_sts_t           sts,
	input  logic [DAY_W-1:0]    start_day,
	input  logic [MONTH_W-1:0]  start_month,
	input  logic [YEAR_W-1:0]   start_year,
	input  logic [COUNT_W-1:0]  add_days,
	output logic [DAY_W-1:0]    end_day,
	output logic [MONTH_W-1:0]  end_month,
	output logic [YEAR_W-1:0]   end_year
);

	localparam int unsigned CNT_W  = (DAY_COUNT_BITS < COUNT_W) ? DAY_COUNT_BITS : COUNT_W;
	localparam int unsigned ACC_W  = CNT_W + 1;
	localparam int unsigned PROD_W = YEAR_W + RECIP_W;

	logic [ACC_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [QUO_W-1:0]   quo_q;
	logic               leap_q;

	logic [ACC_W-1:0]   len_ext;
	logic [PROD_W-1:0]  prod;
	logic [YEAR_W:0]    cent;
	logic [MONTH_W-1:0] month_norm;

	assign len_ext = ACC_W'(month_len(month_q, leap_q));
	assign sts.more = day_q > len_ext;
	assign sts.wrap = month_q == MONTH_DEC;

	assign prod = PROD_W'(year_q) * PROD_W'(RECIP_C100);
	// quo_q * 100 as shifts and adds
	assign cent = ((YEAR_W+1)'(quo_q) << 6) + ((YEAR_W+1)'(quo_q) << 5)
	            + ((YEAR_W+1)'(quo_q) << 2);

	always_comb begin
		month_norm = start_month;
		if (start_month == '0) begin
			month_norm = MONTH_JAN;
		end else if (start_month > MONTH_DEC) begin
			month_norm = MONTH_DEC;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= ACC_W'(start_day) + ACC_W'(add_days[CNT_W-1:0]);
			month_q <= month_norm;
			year_q  <= start_year;
		end else if (cmd.step) begin
			day_q <= day_q - len_ext;
			if (month_q == MONTH_DEC) begin
				month_q <= MONTH_JAN;
				year_q  <= year_q + 1'b1;
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
		if (cmd.quo) begin
			quo_q <= prod[RECIP_SHIFT +: QUO_W];
		end
		if (cmd.leap) begin
			leap_q <= (year_q[1:0] == 2'b00)
			        && (((YEAR_W+1)'(year_q) != cent) || (quo_q[1:0] == 2'b00));
		end
		if (cmd.emit) begin
			end_day   <= day_q[DAY_W-1:0];
			end_month <= month_q;
			end_year  <= year_q;
		end
	end

endmodule

// ===== hw/rtl/gdad_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: load, year / 100 and leap year evaluation, one month per cycle between year carries, result handoff.
// ----------------------------------------------------------------------------
module gdad_ctrl
	import gdad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output gdad_cmd_t cmd,
	input  gdad_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUO,
		ST_LEAP,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit_ok;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign emit_ok   = !out_valid_q || out_ready;

	assign cmd.load = (state_q == ST_IDLE) && in_valid;
	assign cmd.quo  = state_q == ST_QUO;
	assign cmd.leap = state_q == ST_LEAP;
	assign cmd.step = (state_q == ST_RUN) && sts.more;
	assign cmd.emit = (state_q == ST_DONE) && emit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_QUO;
					end
				end
				ST_QUO: begin
					state_q <= ST_LEAP;
				end
				ST_LEAP: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					// a year carry needs a fresh leap flag before the next month
					if (!sts.more) begin
						state_q <= ST_DONE;
					end else if (sts.wrap) begin
						state_q <= ST_QUO;
					end
				end
				ST_DONE: begin
					if (emit_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date, one month length subtracted per cycle between year carries.
// ----------------------------------------------------------------------------
//  channel  role  fields
//  req      sink  start_day[4:0] start_month[3:0] start_year[13:0] add_days[15:0]
//  rsp      src   end_day[4:0] end_month[3:0] end_year[13:0]
//
//  The month loop in the controller subtracts one month per cycle; after each
//  year carry it passes through the year / 100 and leap states to evaluate
//  the leap flag for the new year before it takes the next month.
//  A finished result waits in the output register while the next request is
//  taken. Reset is asynchronous, active low, and clears the control state.
// ----------------------------------------------------------------------------
module gregorian_date_add_days
	import gdad_pkg::*;
#(
	parameter int unsigned DAY_COUNT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	gdad_req_if.sink   req,
	gdad_rsp_if.source rsp
);

	gdad_cmd_t cmd;
	gdad_sts_t sts;

	gdad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	gdad_dpath #(
		.DAY_COUNT_BITS (DAY_COUNT_BITS)
	) u_dpath (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.start_day   (req.start_day),
		.start_month (req.start_month),
		.start_year  (req.start_year),
		.add_days    (req.add_days),
		.end_day     (rsp.end_day),
		.end_month   (rsp.end_month),
		.end_year    (rsp.end_year)
	);

endmodule
